### hw/rtl/esd_pkg.sv
package esd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned QUEUE_DEPTH = 3;

    localparam logic [BYTE_W-1:0] ESC_RESET = 8'd92;

    // Control codes for the escaped letters
    localparam logic [BYTE_W-1:0] CODE_BEL = 8'd7;
    localparam logic [BYTE_W-1:0] CODE_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] CODE_ESC = 8'd27;
    localparam logic [BYTE_W-1:0] CODE_FF  = 8'd12;
    localparam logic [BYTE_W-1:0] CODE_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CODE_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CODE_HT  = 8'd9;
    localparam logic [BYTE_W-1:0] CODE_VT  = 8'd11;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_OCT   = 3'd2,
        MODE_DEC   = 3'd3,
        MODE_HEX   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } t_out_item;

    typedef struct packed {
        t_mode             mode;
        logic [BYTE_W-1:0] acc;
        logic [1:0]        digits;
    } t_parse_state;

    // Results of one transaction, in order
    typedef struct packed {
        logic [1:0] count;
        t_out_item  res1;
        t_out_item  res0;
    } t_results;

endpackage

### hw/rtl/escape_sequence_decoder_core.sv
// Escape sequence decoder: takes an escaped string one byte per transaction
// (in_last marks the final byte) and returns the unescaped bytes, one per
// output transaction, with out_last on the final one. After the escape byte
// (i_cfg_wr_data, default backslash) the letters a b e E f n r t v give
// their control codes, '0' opens an octal number of up to three digits,
// '1'..'9' a decimal number of up to three digits, 'x' a hex number of up
// to two digits; values keep their low 8 bits; any other byte passes
// through. Throughput is one byte per cycle while the output queue has room
// for two results; a byte that both closes a number and yields itself
// produces two results. Each byte passes one input register, then the
// decode logic writes a three-entry output queue. A byte in that register
// moves on to decode only while the queue holds at most one result, since
// it may push two; input is held off while it waits there.
module escape_sequence_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  esd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output esd_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data
);
    import esd_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in_item;
    logic [7:0]   r_escape_byte;
    t_parse_state r_state;
    t_parse_state dec_state;
    t_results     dec_results;
    t_results     push;
    logic         room2;
    logic         advance;

    // Stage 1 moves into decode only when the queue can take two results
    assign advance    = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte <= ESC_RESET;
        end else if (i_cfg_wr_en) begin
            r_escape_byte <= i_cfg_wr_data;
        end
    end

    // Parse state advances once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_PLAIN, acc: '0, digits: '0};
        end else if (advance) begin
            r_state <= dec_state;
        end
    end

    esd_decode u_decode (
        .i_item        (r_in_item),
        .i_state       (r_state),
        .i_escape_byte (r_escape_byte),
        .o_state       (dec_state),
        .o_results     (dec_results)
    );

    always_comb begin
        push = dec_results;
        if (!advance) begin
            push.count = 2'd0;
        end
    end

    esd_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room2     (room2),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/esd_decode.sv
module esd_decode (
    input  esd_pkg::t_in_item     i_item,
    input  esd_pkg::t_parse_state i_state,
    input  logic [7:0]            i_escape_byte,
    output esd_pkg::t_parse_state o_state,
    output esd_pkg::t_results     o_results
);
    import esd_pkg::*;

    logic [BYTE_W-1:0] b;
    logic              last;
    logic              dig_ok;
    logic [3:0]        dig;
    logic [1:0]        limit;
    logic [BYTE_W-1:0] acc_new;
    t_out_item         res [2];
    logic [1:0]        cnt;
    t_parse_state      st;

    assign b    = i_item.in_byte;
    assign last = i_item.in_last;

    // Digit value for the current number base
    always_comb begin
        dig_ok = 1'b0;
        dig    = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            dig    = b[3:0];
            dig_ok = (i_state.mode == MODE_OCT) ? (b <= 8'h37) : 1'b1;
        end else if (i_state.mode == MODE_HEX && b >= 8'h61 && b <= 8'h66) begin
            dig    = 4'(b - 8'h61 + 8'd10);
            dig_ok = 1'b1;
        end else if (i_state.mode == MODE_HEX && b >= 8'h41 && b <= 8'h46) begin
            dig    = 4'(b - 8'h41 + 8'd10);
            dig_ok = 1'b1;
        end
    end

    always_comb begin
        limit   = (i_state.mode == MODE_HEX) ? 2'd2 : 2'd3;
        unique case (i_state.mode)
            MODE_OCT: acc_new = {i_state.acc[4:0], 3'b000} + {4'd0, dig};
            MODE_HEX: acc_new = {i_state.acc[3:0], dig};
            default:  acc_new = {i_state.acc[4:0], 3'b000} + {i_state.acc[6:0], 1'b0}
                              + {4'd0, dig};
        endcase
    end

    always_comb begin
        res[0] = '0;
        res[1] = '0;
        cnt    = '0;
        st     = i_state;

        unique case (i_state.mode)
            MODE_ESC: begin
                st.mode   = MODE_PLAIN;
                st.acc    = '0;
                st.digits = '0;
                cnt       = 2'd1;
                res[0].out_last = last;
                unique case (b)
                    8'h61:        res[0].out_byte = CODE_BEL;
                    8'h62:        res[0].out_byte = CODE_BS;
                    8'h65, 8'h45: res[0].out_byte = CODE_ESC;
                    8'h66:        res[0].out_byte = CODE_FF;
                    8'h6e:        res[0].out_byte = CODE_LF;
                    8'h72:        res[0].out_byte = CODE_CR;
                    8'h74:        res[0].out_byte = CODE_HT;
                    8'h76:        res[0].out_byte = CODE_VT;
                    8'h30: begin
                        st.mode = MODE_OCT;
                        cnt     = 2'd0;
                    end
                    8'h78: begin
                        st.mode = MODE_HEX;
                        cnt     = 2'd0;
                    end
                    default: begin
                        if (b >= 8'h31 && b <= 8'h39) begin
                            st.mode   = MODE_DEC;
                            st.acc    = {4'd0, b[3:0]};
                            st.digits = 2'd1;
                            cnt       = 2'd0;
                        end else begin
                            res[0].out_byte = b;
                        end
                    end
                endcase
            end
            MODE_OCT, MODE_DEC, MODE_HEX: begin
                if (dig_ok && i_state.digits < limit) begin
                    st.acc    = acc_new;
                    st.digits = i_state.digits + 2'd1;
                    if (st.digits >= limit) begin
                        res[0]  = '{out_byte: acc_new, out_last: last};
                        cnt     = 2'd1;
                        st.mode = MODE_PLAIN;
                    end
                end else begin
                    // number ends here; the byte is then taken as plain text
                    res[0]  = '{out_byte: i_state.acc, out_last: 1'b0};
                    st.mode = MODE_PLAIN;
                    if (b == i_escape_byte && !last) begin
                        st.mode = MODE_ESC;
                        cnt     = 2'd1;
                    end else begin
                        res[1] = '{out_byte: b, out_last: last};
                        cnt    = 2'd2;
                    end
                end
            end
            default: begin
                st.mode = MODE_PLAIN;
                if (b == i_escape_byte && !last) begin
                    st.mode = MODE_ESC;
                end else begin
                    res[0] = '{out_byte: b, out_last: last};
                    cnt    = 2'd1;
                end
            end
        endcase

        if (last) begin
            // number cut off by the end of the string
            if (st.mode == MODE_OCT || st.mode == MODE_DEC || st.mode == MODE_HEX) begin
                res[cnt[0]] = '{out_byte: st.acc, out_last: 1'b1};
                cnt         = cnt + 2'd1;
            end
            st.mode   = MODE_PLAIN;
            st.acc    = '0;
            st.digits = '0;
        end
    end

    assign o_state = st;
    assign o_results = '{count: cnt, res1: res[1], res0: res[0]};

endmodule

### hw/rtl/esd_out_queue.sv
module esd_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esd_pkg::t_results  i_push,
    output logic               o_room2,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output esd_pkg::t_out_item o_out_item
);
    import esd_pkg::*;

    t_out_item  r_mem [QUEUE_DEPTH];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [1:0] r_count, n_count;
    logic       pop;
    logic [1:0] wp1;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_mem[r_rp];
    assign pop         = o_out_valid && i_out_ready;
    assign o_room2     = (r_count <= 2'd1);
    assign wp1         = inc3(r_wp);

    always_comb begin
        n_rp    = pop ? inc3(r_rp) : r_rp;
        n_wp    = r_wp;
        if (i_push.count == 2'd1) begin
            n_wp = wp1;
        end else if (i_push.count == 2'd2) begin
            n_wp = inc3(wp1);
        end
        n_count = r_count + i_push.count - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import esd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;     // input register + decode + output queue, with margin
    localparam int HOLD_CYCLES   = 300;   // long receiver stall, fills the output queue
    localparam int PHASE_ITEMS   = 250;
    localparam int PHASE_COUNT   = 8;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the decoder state, predicts the unescaped bytes
    // of every accepted input transaction and checks output transactions
    // against them in order.
    // ------------------------------------------------------------------
    class unescape_scoreboard;
        t_mode      mode;
        logic [7:0] acc;
        logic [1:0] digits;
        logic [7:0] escape_code;
        t_out_item  unescaped_q[$];
        int         errors;

        function new();
            mode        = MODE_PLAIN;
            acc         = '0;
            digits      = '0;
            escape_code = ESC_RESET;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        function void set_escape(logic [7:0] value);
            escape_code = value;
        endfunction

        function void push_result(logic [7:0] b, logic last);
            t_out_item e;
            e.out_byte = b;
            e.out_last = last;
            unescaped_q.push_back(e);
        endfunction

        // value of b as a digit of the current number base, -1 if none
        function int digit_value(logic [7:0] b);
            if (mode == MODE_OCT)
                return (b >= "0" && b <= "7") ? int'(b - "0") : -1;
            if (mode == MODE_DEC)
                return (b >= "0" && b <= "9") ? int'(b - "0") : -1;
            if (b >= "0" && b <= "9") return int'(b - "0");
            if (b >= "a" && b <= "f") return int'(b - "a") + 10;
            if (b >= "A" && b <= "F") return int'(b - "A") + 10;
            return -1;
        endfunction

        function void take_plain(logic [7:0] b, logic last);
            if (b == escape_code) begin
                if (last)
                    push_result(b, 1'b1);     // dangling escape
                else
                    mode = MODE_ESC;
            end else begin
                push_result(b, last);
            end
        endfunction

        function void decode_byte(t_in_item it);
            logic [7:0] b;
            logic       last;
            int         d;
            int         limit;
            int         base;
            b    = it.in_byte;
            last = it.in_last;
            case (mode)
                MODE_ESC: begin
                    mode   = MODE_PLAIN;
                    acc    = '0;
                    digits = '0;
                    case (b)
                        "a":      push_result(CODE_BEL, last);
                        "b":      push_result(CODE_BS, last);
                        "e", "E": push_result(CODE_ESC, last);
                        "f":      push_result(CODE_FF, last);
                        "n":      push_result(CODE_LF, last);
                        "r":      push_result(CODE_CR, last);
                        "t":      push_result(CODE_HT, last);
                        "v":      push_result(CODE_VT, last);
                        "0":      mode = MODE_OCT;
                        "x":      mode = MODE_HEX;
                        "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
                            mode   = MODE_DEC;
                            acc    = b - "0";
                            digits = 2'd1;
                        end
                        default:  push_result(b, last);
                    endcase
                end
                MODE_OCT, MODE_DEC, MODE_HEX: begin
                    limit = (mode == MODE_HEX) ? 2 : 3;
                    base  = (mode == MODE_OCT) ? 8 : (mode == MODE_DEC) ? 10 : 16;
                    d     = digit_value(b);
                    if (d >= 0 && int'(digits) < limit) begin
                        acc    = 8'(int'(acc) * base + d);
                        digits = digits + 2'd1;
                        if (int'(digits) >= limit) begin
                            push_result(acc, last);
                            mode = MODE_PLAIN;
                        end
                    end else begin
                        // number closed by a non-digit, which is then decoded as usual
                        push_result(acc, 1'b0);
                        mode = MODE_PLAIN;
                        take_plain(b, last);
                    end
                end
                default: begin
                    mode = MODE_PLAIN;
                    take_plain(b, last);
                end
            endcase
            if (last) begin
                if (mode == MODE_OCT || mode == MODE_DEC || mode == MODE_HEX)
                    push_result(acc, 1'b1);
                mode   = MODE_PLAIN;
                acc    = '0;
                digits = '0;
            end
        endfunction

        task compare_result(t_out_item got);
            t_out_item want;
            if (unescaped_q.size() == 0) begin
                report($sformatf("result byte %02h last %0d with nothing expected",
                                 got.out_byte, got.out_last));
            end else begin
                want = unescaped_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, expected %02h",
                                     got.out_byte, want.out_byte));
                if (got.out_last !== want.out_last)
                    report($sformatf("out_last %0d, expected %0d (byte %02h)",
                                     got.out_last, want.out_last, want.out_byte));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    t_in_item   in_item     = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    t_out_item  out_item;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    unescape_scoreboard sb = new();

    // knobs and counters for the driver, the result sink and the watchdog
    bit         tx_idle_on  = 1'b1;
    bit         rx_idle_on  = 1'b1;
    bit         hold_req    = 1'b0;
    logic [7:0] cur_escape  = ESC_RESET;
    int         sent_items  = 0;
    int         cycle_count = 0;

    escape_sequence_decoder_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input side. One transaction per call; an optional gap with valid
    // low goes first. With no gap, valid simply stays high from the
    // previous transaction. All drives happen right after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_item(logic [7:0] b, logic last);
        int       gap;
        t_in_item it;
        gap        = tx_idle_on ? $urandom_range(0, 14) : 0;
        it.in_byte = b;
        it.in_last = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.decode_byte(it);
        sent_items++;
    endtask

    task automatic send_text(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Stop offering, let every expected result come out, then let the
    // pipeline settle: a trailing escape or digit produces no result yet
    // may still be in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.unescaped_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Escape byte register write, only ever issued while the block is idle
    task automatic write_escape(logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_escape(value);
        cur_escape = value;
    endtask

    // One string. Mostly well-formed tokens built around the current escape
    // byte (control letters, octal/decimal/hex numbers of every length,
    // escaped arbitrary bytes, escaped escape), ending on a last byte.
    // About one call in ten is raw noise with random last flags.
    task automatic send_random_string();
        logic [7:0] raw_q[$];
        int         kind;
        string      letters;
        string      hex_digits;
        letters    = "abeEfnrtv";
        hex_digits = "0123456789abcdefABCDEF";
        tx_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    raw_q.push_back(8'($urandom_range(32, 126)));
                end else if (kind < 45) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back(letters[$urandom_range(0, 8)]);
                end else if (kind < 55) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back("0");
                    repeat ($urandom_range(0, 3))
                        raw_q.push_back(8'("0" + $urandom_range(0, 7)));
                end else if (kind < 65) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back(8'("1" + $urandom_range(0, 8)));
                    repeat ($urandom_range(0, 2))
                        raw_q.push_back(8'("0" + $urandom_range(0, 9)));
                end else if (kind < 75) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back("x");
                    repeat ($urandom_range(0, 2))
                        raw_q.push_back(hex_digits[$urandom_range(0, 21)]);
                end else if (kind < 85) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back(8'($urandom_range(0, 255)));
                end else if (kind < 90) begin
                    raw_q.push_back(cur_escape);
                    raw_q.push_back(cur_escape);
                end else begin
                    raw_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            foreach (raw_q[i])
                send_item(raw_q[i], (i == raw_q.size() - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. Draws a stall before every transaction while rx_idle_on
    // is set; once, on request, the stall is stretched long enough that the
    // output queue fills and the block must hold off its input.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap += HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.compare_result(out_item);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] escape_plan [PHASE_COUNT];
        int         phase_start;
        // extremes, escape bytes that collide with letters and digits,
        // back to backslash, then one arbitrary value
        escape_plan = '{8'd0, 8'd255, "n", "5", "x", "0", ESC_RESET, 8'd0};
        escape_plan[PHASE_COUNT - 1] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset escape byte (backslash)
        send_item(8'h00, 1'b0);             // plain byte extremes
        send_item(8'hFF, 1'b0);
        send_text("\\a\\E\\v", 1'b0);       // control letters
        send_text("\\", 1'b0);              // zero byte after escape passes through
        send_item(8'h00, 1'b0);
        send_text("\\078", 1'b0);           // octal closed by a non-digit: two results
        send_text("\\999", 1'b0);           // decimal, full budget, wraps to 8 bits
        send_text("\\xfF", 1'b0);           // hex with both letter cases
        send_text("\\\\", 1'b0);            // escaped escape
        send_text("\\x", 1'b1);             // number cut by end of string
        send_text("\\", 1'b1);              // dangling escape
        drain();

        // Random part, one escape setting per phase
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_escape(escape_plan[p]);
            rx_idle_on = (p % 3 != 1);
            if (p == 2)
                hold_req = 1'b1;
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
                send_random_string();
            drain();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_decode.sv
hw/rtl/esd_out_queue.sv
hw/rtl/escape_sequence_decoder_core.sv
tb/testbench.sv
